/* rtl/core/ptocc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptocc_pkg
// Types and constants shared by the octree cell code pipeline.
// ----------------------------------------------------------------------------
package ptocc_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_ADDR_W-1:0] CFG_ORIGIN_X    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ORIGIN_Y    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_ORIGIN_Z    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_ROOT_RADIUS = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_INV_EXTENT  = 3'd4;

    localparam logic [31:0] ROOT_RADIUS_RST = 32'd65536;
    localparam logic [31:0] INV_EXTENT_RST  = 32'd8388608;

    // bits of cell index per axis, fraction bits of a normalized coordinate
    localparam int CODE_BITS = 21;
    localparam int FRAC_N    = 24;
    localparam int DEPTH_W   = 5;
    localparam int CODE_W    = 3 * CODE_BITS;

    typedef struct packed {
        logic               sample_valid;
        logic [31:0]        footprint;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } sample_t;

    typedef struct packed {
        logic               accepted;
        logic [CODE_W-1:0]  cell_code;
        logic [DEPTH_W-1:0] cell_depth;
        logic [31:0]        cell_radius;
    } result_t;

endpackage

/* rtl/core/ptocc_axis.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptocc_axis
// Normalizes one coordinate into the scene cube over two register stages:
// offset from the cube corner, then scale by the inverse extent.
// ----------------------------------------------------------------------------
module ptocc_axis (
    input  logic                          clk,
    input  logic signed [31:0]            point,
    input  logic signed [31:0]            origin,
    input  logic [31:0]                   inv_extent,
    output logic [ptocc_pkg::FRAC_N-1:0]  norm,
    output logic                          in_cube
);
    import ptocc_pkg::*;

    logic signed [32:0]  diff;
    logic                neg_reg;
    logic [31:0]         mag_reg;
    logic [63:0]         prod;
    logic [FRAC_N-1:0]   norm_reg;
    logic                in_cube_reg;

    assign diff = {point[31], point} - {origin[31], origin};
    assign prod = mag_reg * inv_extent;

    always_ff @(posedge clk)
    begin
        neg_reg     <= diff[32];
        mag_reg     <= diff[31:0];
        // product is Q24.40; in [0,1) means nothing at or above bit 40
        norm_reg    <= prod[16+FRAC_N-1:16];
        in_cube_reg <= !neg_reg && (prod[63:16+FRAC_N] == '0);
    end

    assign norm    = norm_reg;
    assign in_cube = in_cube_reg;

endmodule

/* rtl/core/point_to_octree_cell_code.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_to_octree_cell_code
// Maps a 3D point with footprint radius onto an octree cell: depth from the
// radius, per-axis quantization, 63-bit Morton code.
// ----------------------------------------------------------------------------
//  channel   signals                          transfer
//  sample    start, busy, sample              start && !busy
//  result    done, result                     done (one cycle, no backpressure)
//  config    cfg_we, cfg_addr, cfg_wdata      cfg_we
//
// One transaction per cycle; start reaches done through the offset, multiply
// and encode stages. busy stays low.
// Reset clears the valid chain and loads the register defaults.
// The pipeline never stalls since the receiver takes every result.
// ----------------------------------------------------------------------------
module point_to_octree_cell_code #(
    parameter int DEPTH_LIMIT = 21
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  ptocc_pkg::sample_t               sample,
    output logic                             done,
    output ptocc_pkg::result_t               result,
    input  logic                             cfg_we,
    input  logic [ptocc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [ptocc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import ptocc_pkg::*;

    localparam int SHIFT_W = 2 * 32 + DEPTH_LIMIT;

    logic signed [31:0] origin_x_reg, origin_y_reg, origin_z_reg;
    logic [31:0]        root_radius_reg, inv_extent_reg;

    logic               take;
    logic [33:0]        three_r;
    logic [32:0]        two_root;
    logic [DEPTH_LIMIT-1:0] fits;

    logic               s1_valid_reg, s2_valid_reg, done_reg;
    logic               s1_ok_reg, s2_ok_reg;
    logic [31:0]        s1_radius_reg, s2_radius_reg;
    logic [DEPTH_LIMIT-1:0] s1_fits_reg;
    logic [DEPTH_W-1:0] depth_next, s2_depth_reg;

    logic [FRAC_N-1:0]  norm_x, norm_y, norm_z;
    logic               in_x, in_y, in_z;
    logic               accept_now;
    logic [CODE_W-1:0]  code_next;
    result_t            result_next, result_reg;

    assign take = start && !busy;
    assign busy = 1'b0;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg    <= '0;
            origin_y_reg    <= '0;
            origin_z_reg    <= '0;
            root_radius_reg <= ROOT_RADIUS_RST;
            inv_extent_reg  <= INV_EXTENT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_ORIGIN_X:    origin_x_reg    <= cfg_wdata;
                CFG_ORIGIN_Y:    origin_y_reg    <= cfg_wdata;
                CFG_ORIGIN_Z:    origin_z_reg    <= cfg_wdata;
                CFG_ROOT_RADIUS: root_radius_reg <= cfg_wdata;
                CFG_INV_EXTENT:  inv_extent_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // stage 1: depth tests, fits[k] means level k is still too coarse
    assign three_r  = {1'b0, sample.footprint, 1'b0} + {2'b00, sample.footprint};
    assign two_root = {root_radius_reg, 1'b0};

    always_comb
    begin
        for (int k = 0; k < DEPTH_LIMIT; k++)
        begin
            fits[k] = ({{(SHIFT_W-34){1'b0}}, three_r} << k)
                      <= {{(SHIFT_W-33){1'b0}}, two_root};
        end
    end

    ptocc_axis u_axis_x (
        .clk(clk), .point(sample.point_x), .origin(origin_x_reg),
        .inv_extent(inv_extent_reg), .norm(norm_x), .in_cube(in_x)
    );
    ptocc_axis u_axis_y (
        .clk(clk), .point(sample.point_y), .origin(origin_y_reg),
        .inv_extent(inv_extent_reg), .norm(norm_y), .in_cube(in_y)
    );
    ptocc_axis u_axis_z (
        .clk(clk), .point(sample.point_z), .origin(origin_z_reg),
        .inv_extent(inv_extent_reg), .norm(norm_z), .in_cube(in_z)
    );

    // stage 2: fits is a run of ones then zeros; depth is where it ends
    always_comb
    begin
        depth_next = '0;
        for (int k = 0; k <= DEPTH_LIMIT; k++)
        begin
            if (((k == 0) || s1_fits_reg[(k == 0) ? 0 : k-1])
                && ((k == DEPTH_LIMIT) || !s1_fits_reg[(k == DEPTH_LIMIT) ? 0 : k]))
            begin
                depth_next = depth_next | DEPTH_W'(k);
            end
        end
    end

    // stage 3: keep the top depth bits of each index, then interleave
    assign accept_now = s2_ok_reg && in_x && in_y && in_z;

    always_comb
    begin
        for (int j = 0; j < CODE_BITS; j++)
        begin
            code_next[3*j]   = norm_x[FRAC_N-CODE_BITS+j] && (j + int'(s2_depth_reg) >= CODE_BITS);
            code_next[3*j+1] = norm_y[FRAC_N-CODE_BITS+j] && (j + int'(s2_depth_reg) >= CODE_BITS);
            code_next[3*j+2] = norm_z[FRAC_N-CODE_BITS+j] && (j + int'(s2_depth_reg) >= CODE_BITS);
        end
        result_next = '0;
        if (accept_now)
        begin
            result_next.accepted    = 1'b1;
            result_next.cell_code   = code_next;
            result_next.cell_depth  = s2_depth_reg;
            result_next.cell_radius = s2_radius_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= take;
            s2_valid_reg <= s1_valid_reg;
            done_reg     <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_ok_reg     <= sample.sample_valid && (sample.footprint != '0);
        s1_radius_reg <= sample.footprint;
        s1_fits_reg   <= fits;
        s2_ok_reg     <= s1_ok_reg;
        s2_radius_reg <= s1_radius_reg;
        s2_depth_reg  <= depth_next;
        result_reg    <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 3))
        else $error("result without a transaction three cycles earlier");

    a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.cell_depth <= DEPTH_W'(DEPTH_LIMIT)))
        else $error("cell depth beyond maximum");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.accepted) |->
            (result.cell_code == '0 && result.cell_depth == '0
             && result.cell_radius == '0))
        else $error("rejected result carries nonzero fields");

    a_accept_radius: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.accepted) |-> (result.cell_radius != '0))
        else $error("accepted result with zero radius");

endmodule
